// File: rtl/fea_pkg.sv
`default_nettype none
package fea_pkg;

   localparam int MAX_RECORDS = 32;
   localparam int EXT_DEPTH   = MAX_RECORDS + 1;
   localparam int REC_AW      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int REC_CW      = $clog2(MAX_RECORDS + 1);
   localparam int EXT_AW      = $clog2(EXT_DEPTH);
   localparam int EXT_CW      = $clog2(EXT_DEPTH + 1);
   localparam int SECTOR_SH   = 12;
   localparam int SEC_W       = 20;

   localparam logic [31:0] ADDR_NONE = 32'hFFFF_FFFF;

   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD    = 2'd0;
   localparam op_type OP_REBUILD = 2'd1;
   localparam op_type OP_ALLOC   = 2'd2;
   localparam op_type OP_NONE    = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_NOFIT = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_REGION_START = 1'd0;
   localparam csr_index_type CSR_FLASH_END    = 1'd1;

endpackage
`default_nettype wire

// File: rtl/fea_ram.sv
`default_nettype none
module fea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/flash_extent_allocator.sv
`default_nettype none
// Sector-granular first-fit allocator for a flash region of 4096-byte
// sectors. Every item started (start high while busy low) produces exactly
// one result, shown for a single cycle with rsp_valid; the receiver cannot
// stall, so rsp_* must be captured on that cycle. Loads and the unused op
// answer in the next cycle and leave busy low. A rebuild makes, for each
// sorted position, a full pass over the record RAM (the RAM has one
// registered read port) plus one walk step. An allocate scans extents up
// to the hit, then moves later extents down when an extent is consumed
// whole (extent RAM, one read and one write port).
// Registers (csr_index): 0 region_start, 1 flash_end; write them only idle.
module flash_extent_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire fea_pkg::op_type             req_op,
   input  wire logic                        req_slot_used,
   input  wire logic [31:0]                 req_entry_addr,
   input  wire logic [31:0]                 req_entry_size,
   input  wire logic [31:0]                 req_alloc_len,
   output logic                             rsp_valid,
   output logic [31:0]                      rsp_alloc_addr,
   output logic                             rsp_found,
   output fea_pkg::status_type              rsp_status,
   output logic [5:0]                       rsp_extent_count,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire fea_pkg::csr_index_type      csr_index,
   input  wire logic [31:0]                 csr_wdata
);
   import fea_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;  // find next record in sort order
   localparam logic [2:0] S_WALK  = 3'd2;  // fold that record into the gap walk
   localparam logic [2:0] S_TAIL  = 3'd3;
   localparam logic [2:0] S_AFIND = 3'd4;  // first-fit search
   localparam logic [2:0] S_SHIFT = 3'd5;  // close the hole of a removed extent

   localparam int KEY_W = 32 + REC_AW;

   logic [2:0]        state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [31:0]       region_ff, region_in;
   logic [31:0]       fend_ff, fend_in;
   logic [REC_CW-1:0] rcnt_ff, rcnt_in;
   logic [EXT_CW-1:0] etot_ff, etot_in;
   logic [REC_AW-1:0] sidx_ff, sidx_in;
   logic [REC_CW-1:0] left_ff, left_in;
   logic              bestv_ff, bestv_in;
   logic [KEY_W-1:0]  bkey_ff, bkey_in;
   logic [31:0]       bsize_ff, bsize_in;
   logic              lastv_ff, lastv_in;
   logic [KEY_W-1:0]  lkey_ff, lkey_in;
   logic [32:0]       off_ff, off_in;
   logic [EXT_AW-1:0] eidx_ff, eidx_in;
   logic [31:0]       alen_ff, alen_in;
   logic              rv_ff, rv_in;
   logic [31:0]       raddr_ff, raddr_in;
   logic              rfound_ff, rfound_in;
   status_type        rstat_ff, rstat_in;

   // record RAM: {addr, size}; extent RAM: {start, sectors}
   logic              rec_we;
   logic [REC_AW-1:0] rec_waddr;
   logic [63:0]       rec_rdata;
   logic              ext_we;
   logic [EXT_AW-1:0] ext_waddr, ext_raddr;
   logic [51:0]       ext_wdata, ext_rdata;

   fea_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata ({req_entry_addr, req_entry_size}),
      .raddr (sidx_ff),
      .rdata (rec_rdata)
   );

   fea_ram #(.WIDTH(52), .DEPTH(EXT_DEPTH)) u_ext_ram (
      .clock (clock),
      .we    (ext_we),
      .waddr (ext_waddr),
      .wdata (ext_wdata),
      .raddr (ext_raddr),
      .rdata (ext_rdata)
   );

   logic              accept, keep_rec;
   logic [KEY_W-1:0]  cur_key;
   logic [20:0]       bsecs;
   logic [32:0]       rec_end, gap, tail;
   logic [31:0]       x_start, x_bytes;
   logic [SEC_W-1:0]  x_secs;
   logic [20:0]       need, remain;
   logic              last_ext;

   assign accept   = start && !busy;
   assign keep_rec = req_slot_used && (req_entry_addr != ADDR_NONE) && (req_entry_size != '0);
   assign cur_key  = {rec_rdata[63:32], sidx_ff};
   // record end rounded up to a sector; 33 bits so ends past 4 GiB don't wrap
   assign bsecs    = {1'b0, bsize_ff[31:SECTOR_SH]} + 21'(|bsize_ff[SECTOR_SH-1:0]);
   assign rec_end  = {1'b0, bkey_ff[KEY_W-1:REC_AW]} + {bsecs, 12'b0};
   assign gap      = {1'b0, bkey_ff[KEY_W-1:REC_AW]} - off_ff;
   assign tail     = {1'b0, fend_ff} - off_ff;
   assign x_start  = ext_rdata[51:20];
   assign x_secs   = ext_rdata[19:0];
   assign x_bytes  = {x_secs, 12'b0};
   assign need     = {1'b0, alen_ff[31:SECTOR_SH]} + 21'(|alen_ff[SECTOR_SH-1:0]);
   assign remain   = {1'b0, x_secs} - need;
   assign last_ext = (EXT_CW'(eidx_ff) + EXT_CW'(1)) == etot_ff;

   // during a shift the read address runs one above the write address, so the
   // entry being copied is never the one written in that cycle
   assign ext_raddr = (state_ff == S_SHIFT) ? EXT_AW'(eidx_ff + EXT_AW'(1)) : eidx_ff;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      region_in = region_ff;
      fend_in   = fend_ff;
      rcnt_in   = rcnt_ff;
      etot_in   = etot_ff;
      sidx_in   = sidx_ff;
      left_in   = left_ff;
      bestv_in  = bestv_ff;
      bkey_in   = bkey_ff;
      bsize_in  = bsize_ff;
      lastv_in  = lastv_ff;
      lkey_in   = lkey_ff;
      off_in    = off_ff;
      eidx_in   = eidx_ff;
      alen_in   = alen_ff;
      rv_in     = 1'b0;
      raddr_in  = raddr_ff;
      rfound_in = rfound_ff;
      rstat_in  = rstat_ff;
      rec_we    = 1'b0;
      rec_waddr = REC_AW'(rcnt_ff);
      ext_we    = 1'b0;
      ext_waddr = EXT_AW'(etot_ff);
      ext_wdata = {off_ff[31:0], gap[31:12]};

      if (csr_valid) begin
         unique case (csr_index)
            CSR_REGION_START: region_in = csr_wdata;
            CSR_FLASH_END:    fend_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               alen_in   = req_alloc_len;
               raddr_in  = '0;
               rfound_in = 1'b0;
               rstat_in  = ST_DONE;
               phase_in  = 1'b0;
               unique case (req_op)
                  OP_LOAD: begin
                     rv_in = 1'b1;
                     if (keep_rec) begin
                        if (rcnt_ff < REC_CW'(MAX_RECORDS)) begin
                           rec_we  = 1'b1;
                           rcnt_in = rcnt_ff + REC_CW'(1);
                        end else begin
                           rstat_in = ST_FULL;
                        end
                     end
                  end
                  OP_REBUILD: begin
                     off_in   = {1'b0, region_ff};
                     etot_in  = '0;
                     left_in  = rcnt_ff;
                     lastv_in = 1'b0;
                     bestv_in = 1'b0;
                     sidx_in  = '0;
                     state_in = (rcnt_ff == '0) ? S_TAIL : S_SCAN;
                  end
                  OP_ALLOC: begin
                     eidx_in = '0;
                     if (etot_ff == '0) begin
                        rstat_in = ST_NOFIT;
                        rv_in    = 1'b1;
                     end else begin
                        state_in = S_AFIND;
                     end
                  end
                  OP_NONE: rv_in = 1'b1;
                  default: rv_in = 1'b1;
               endcase
            end
         end

         S_SCAN: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               // smallest (addr, load index) above the last one taken
               if ((!lastv_ff || cur_key > lkey_ff) && (!bestv_ff || cur_key < bkey_ff)) begin
                  bestv_in = 1'b1;
                  bkey_in  = cur_key;
                  bsize_in = rec_rdata[31:0];
               end
               if (REC_CW'(sidx_ff) + REC_CW'(1) == rcnt_ff) begin
                  state_in = S_WALK;
               end else begin
                  sidx_in = sidx_ff + REC_AW'(1);
               end
            end
         end

         S_WALK: begin
            if (off_ff < {1'b0, bkey_ff[KEY_W-1:REC_AW]}) begin
               ext_we  = 1'b1;
               etot_in = etot_ff + EXT_CW'(1);
               off_in  = rec_end;
            end else if (off_ff == {1'b0, bkey_ff[KEY_W-1:REC_AW]}) begin
               off_in = rec_end;
            end
            lastv_in = 1'b1;
            lkey_in  = bkey_ff;
            bestv_in = 1'b0;
            sidx_in  = '0;
            phase_in = 1'b0;
            left_in  = left_ff - REC_CW'(1);
            state_in = (left_ff == REC_CW'(1)) ? S_TAIL : S_SCAN;
         end

         S_TAIL: begin
            if (off_ff < {1'b0, fend_ff}) begin
               ext_we    = 1'b1;
               ext_wdata = {off_ff[31:0], tail[31:12]};
               etot_in   = etot_ff + EXT_CW'(1);
            end
            rcnt_in  = '0;
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end

         S_AFIND: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if ({1'b0, alen_ff} < {1'b0, x_bytes}) begin
                  raddr_in  = x_start;
                  rfound_in = 1'b1;
                  if (remain > 21'd1) begin
                     ext_we    = 1'b1;
                     ext_waddr = eidx_ff;
                     ext_wdata = {x_start + {need[19:0], 12'b0}, remain[19:0]};
                     rv_in     = 1'b1;
                     state_in  = S_IDLE;
                  end else if (last_ext) begin
                     etot_in  = etot_ff - EXT_CW'(1);
                     rv_in    = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_SHIFT;
                  end
               end else if (last_ext) begin
                  rstat_in = ST_NOFIT;
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  eidx_in = eidx_ff + EXT_AW'(1);
               end
            end
         end

         S_SHIFT: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               ext_we    = 1'b1;
               ext_waddr = eidx_ff;
               ext_wdata = ext_rdata;
               if (EXT_CW'(eidx_ff) + EXT_CW'(2) == etot_ff) begin
                  etot_in  = etot_ff - EXT_CW'(1);
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  eidx_in = eidx_ff + EXT_AW'(1);
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= 1'b0;
         region_ff <= 32'd4096;
         fend_ff   <= 32'd16777216;
         rcnt_ff   <= '0;
         etot_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         region_ff <= region_in;
         fend_ff   <= fend_in;
         rcnt_ff   <= rcnt_in;
         etot_ff   <= etot_in;
         rv_ff     <= rv_in;
      end
      sidx_ff   <= sidx_in;
      left_ff   <= left_in;
      bestv_ff  <= bestv_in;
      bkey_ff   <= bkey_in;
      bsize_ff  <= bsize_in;
      lastv_ff  <= lastv_in;
      lkey_ff   <= lkey_in;
      off_ff    <= off_in;
      eidx_ff   <= eidx_in;
      alen_ff   <= alen_in;
      raddr_ff  <= raddr_in;
      rfound_ff <= rfound_in;
      rstat_ff  <= rstat_in;
   end

   // extent count reported is the count after the item
   logic [EXT_CW-1:0] cnt_out_ff;
   always_ff @(posedge clock) begin
      cnt_out_ff <= etot_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rv_ff;
   assign rsp_alloc_addr   = raddr_ff;
   assign rsp_found        = rfound_ff;
   assign rsp_status       = rstat_ff;
   assign rsp_extent_count = 6'(cnt_out_ff);
endmodule
`default_nettype wire

// File: rtl/fea_check.sv
`default_nettype none
module fea_check (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [31:0]         rsp_alloc_addr,
   input wire logic                rsp_found,
   input wire fea_pkg::status_type rsp_status,
   input wire logic [5:0]          rsp_extent_count
);
   import fea_pkg::*;

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_DONE)
      else $error("grant with error status");

   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_alloc_addr == 32'd0)
      else $error("address without grant");

   a_follow: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("item neither answered nor in work");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("work ended without a result");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_extent_count <= 6'(EXT_DEPTH))
      else $error("extent count out of range");
endmodule

bind flash_extent_allocator fea_check u_fea_check (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_alloc_addr   (rsp_alloc_addr),
   .rsp_found        (rsp_found),
   .rsp_status       (rsp_status),
   .rsp_extent_count (rsp_extent_count)
);
`default_nettype wire

// File: tb/tb_flash_extent_allocator.sv
`default_nettype none
module tb_flash_extent_allocator;
   import fea_pkg::*;

   // Cycles without any handshake before the run is declared hung. The slowest
   // item is a rebuild of a full record store.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_ITEMS      = 600;
   localparam int QUIET_TAIL     = 500;   // no idling once this many items went out
   localparam int SETTLE_CYCLES  = 8;
   localparam int NUM_DIRECTED   = 22;
   localparam logic [31:0] SECTOR = 32'd4096;

   typedef struct packed {
      op_type      op;
      logic        slot_used;
      logic [31:0] entry_addr;
      logic [31:0] entry_size;
      logic [31:0] alloc_len;
   } item_type;

   typedef struct packed {
      logic [31:0] alloc_addr;
      logic        found;
      status_type  status;
      logic [5:0]  extent_count;
   } result_type;

   typedef struct packed {
      item_type   item;
      logic       typed;    // expectation given in the row itself
      result_type res;
   } row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   op_type              req_op;
   logic                req_slot_used;
   logic [31:0]         req_entry_addr;
   logic [31:0]         req_entry_size;
   logic [31:0]         req_alloc_len;
   logic                rsp_valid;
   logic [31:0]         rsp_alloc_addr;
   logic                rsp_found;
   status_type          rsp_status;
   logic [5:0]          rsp_extent_count;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [31:0]         csr_wdata;

   flash_extent_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot_used    (req_slot_used),
      .req_entry_addr   (req_entry_addr),
      .req_entry_size   (req_entry_size),
      .req_alloc_len    (req_alloc_len),
      .rsp_valid        (rsp_valid),
      .rsp_alloc_addr   (rsp_alloc_addr),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_extent_count (rsp_extent_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the allocator: configuration, record store, extents.
   // ---------------------------------------------------------------------
   logic [31:0] sh_region_start;
   logic [31:0] sh_flash_end;
   logic [31:0] rec_addr [MAX_RECORDS];
   logic [31:0] rec_size [MAX_RECORDS];
   int          rec_n;
   logic [31:0] ext_start [EXT_DEPTH];
   logic [19:0] ext_secs  [EXT_DEPTH];
   int          ext_n;

   result_type pending_results [$];   // what the block still owes us, oldest first
   int         errors;
   int         items_taken;
   int         csr_taken;
   int         items_sent;
   int         stall_count;
   logic       use_typed;
   result_type typed_res;
   logic       idling_on;

   function automatic void add_extent(longint unsigned at, longint unsigned secs);
      if (ext_n < EXT_DEPTH) begin
         ext_start[ext_n] = at[31:0];
         ext_secs[ext_n]  = secs[19:0];
         ext_n++;
      end
   endfunction

   // Stable insertion sort by address, then the gap walk from region_start.
   // The walk offset is 64 bits so record ends past 4 GiB do not wrap.
   function automatic void rebuild_extents();
      int              j;
      logic [31:0]     a, s;
      longint unsigned offs, ra, nsec;
      for (int i = 1; i < rec_n; i++) begin
         a = rec_addr[i];
         s = rec_size[i];
         j = i;
         while (j > 0 && rec_addr[j-1] > a) begin
            rec_addr[j] = rec_addr[j-1];
            rec_size[j] = rec_size[j-1];
            j--;
         end
         rec_addr[j] = a;
         rec_size[j] = s;
      end
      offs  = sh_region_start;
      ext_n = 0;
      for (int i = 0; i < rec_n; i++) begin
         ra   = rec_addr[i];
         nsec = ({32'd0, rec_size[i]} + 64'd4095) >> 12;
         if (offs < ra) begin
            add_extent(offs, (ra - offs) >> 12);
            offs = ra + (nsec << 12);
         end else if (offs == ra) begin
            offs = ra + (nsec << 12);
         end
         // records below the offset overlap and are skipped
      end
      if (offs < {32'd0, sh_flash_end})
         add_extent(offs, ({32'd0, sh_flash_end} - offs) >> 12);
      rec_n = 0;
   endfunction

   // First fit: extent must be strictly larger than the request in bytes.
   function automatic logic grant_extent(input logic [31:0] len, output logic [31:0] at);
      longint unsigned need, bytes;
      at   = '0;
      need = ({32'd0, len} + 64'd4095) >> 12;
      for (int i = 0; i < ext_n; i++) begin
         bytes = {44'd0, ext_secs[i]} << 12;
         if ({32'd0, len} < bytes) begin
            at = ext_start[i];
            if (bytes - (need << 12) > 64'd4096) begin
               ext_secs[i]  = ext_secs[i] - need[19:0];
               ext_start[i] = ext_start[i] + need[31:0] * SECTOR;
            end else begin
               for (int k = i; k + 1 < ext_n; k++) begin
                  ext_start[k] = ext_start[k+1];
                  ext_secs[k]  = ext_secs[k+1];
               end
               ext_n--;
            end
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic result_type predict_result(item_type it);
      result_type  r;
      logic [31:0] at;
      r = '0;
      case (it.op)
         OP_LOAD: begin
            if (it.slot_used && it.entry_addr != ADDR_NONE && it.entry_size != 0) begin
               if (rec_n < MAX_RECORDS) begin
                  rec_addr[rec_n] = it.entry_addr;
                  rec_size[rec_n] = it.entry_size;
                  rec_n++;
               end else begin
                  r.status = ST_FULL;
               end
            end
         end
         OP_REBUILD: rebuild_extents();
         OP_ALLOC: begin
            if (grant_extent(it.alloc_len, at)) begin
               r.found      = 1'b1;
               r.alloc_addr = at;
            end else begin
               r.status = ST_NOFIT;
            end
         end
         default: ;   // unused op: nothing happens
      endcase
      r.extent_count = ext_n[5:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic       moved;
      result_type want;
      item_type   it;
      if (reset) begin
         stall_count = 0;
      end else begin
         moved = 1'b0;
         if (start && !busy) begin
            moved         = 1'b1;
            it.op         = req_op;
            it.slot_used  = req_slot_used;
            it.entry_addr = req_entry_addr;
            it.entry_size = req_entry_size;
            it.alloc_len  = req_alloc_len;
            want = predict_result(it);
            if (use_typed)
               want = typed_res;
            pending_results.push_back(want);
            items_taken++;
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == CSR_REGION_START)
               sh_region_start = csr_wdata;
            else
               sh_flash_end = csr_wdata;
            csr_taken++;
         end
         if (rsp_valid) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected item", 32'd0, 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_alloc_addr !== want.alloc_addr)
                  report_mismatch("alloc_addr", rsp_alloc_addr, want.alloc_addr);
               if (rsp_found !== want.found)
                  report_mismatch("found", 32'(rsp_found), 32'(want.found));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_extent_count !== want.extent_count)
                  report_mismatch("extent_count", 32'(rsp_extent_count),
                                  32'(want.extent_count));
            end
         end
         stall_count = moved ? 0 : stall_count + 1;
         if (stall_count >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: inputs change on the falling edge only.
   // ---------------------------------------------------------------------
   // Holds start until the item is taken; start stays high into the next
   // item unless an idle burst is drawn.
   task automatic send_item(item_type it, logic typed, result_type res);
      int seen;
      use_typed      = typed;
      typed_res      = res;
      req_op         = it.op;
      req_slot_used  = it.slot_used;
      req_entry_addr = it.entry_addr;
      req_entry_size = it.entry_size;
      req_alloc_len  = it.alloc_len;
      start          = 1'b1;
      seen           = items_taken;
      while (items_taken == seen)
         @(negedge clock);
      items_sent++;
      if (items_sent >= QUIET_TAIL)
         idling_on = 1'b0;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic send_plain(item_type it);
      send_item(it, 1'b0, '0);
   endtask

   // Wait for every owed item and for the block to go quiet.
   task automatic drain();
      start = 1'b0;
      while (pending_results.size() != 0 || busy)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      int seen;
      drain();
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      seen      = csr_taken;
      while (csr_taken == seen)
         @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Random field generators
   // ---------------------------------------------------------------------
   function automatic logic [31:0] pick_record_addr();
      logic [31:0] a;
      if ($urandom_range(0, 9) == 0)
         return $urandom();
      a = sh_region_start + $urandom_range(0, 400) * SECTOR;
      if ($urandom_range(0, 4) == 0)
         a = a + $urandom_range(1, 4095);       // unaligned start
      return a;
   endfunction

   function automatic logic [31:0] pick_record_size();
      if ($urandom_range(0, 9) == 0)
         return $urandom();
      if ($urandom_range(0, 2) == 0)
         return $urandom_range(1, 6) * SECTOR;  // whole sectors
      return $urandom_range(1, 6 * 4096);
   endfunction

   function automatic logic [31:0] pick_alloc_len();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'd0;
         2, 3:    return $urandom_range(1, 8) * SECTOR;
         4:       return $urandom_range(1, 8) * SECTOR - 1;
         default: return $urandom_range(1, 12 * 4096);
      endcase
   endfunction

   function automatic item_type pick_noise();
      item_type it;
      it = '{op: OP_LOAD, slot_used: 1'b1, entry_addr: $urandom(), entry_size: $urandom(),
             alloc_len: $urandom()};
      case ($urandom_range(0, 3))
         0: it.slot_used  = 1'b0;
         1: it.entry_addr = ADDR_NONE;
         2: it.entry_size = 32'd0;
         default: it.op   = OP_NONE;
      endcase
      return it;
   endfunction

   // One well-formed sequence: records, rebuild, then allocations,
   // sprinkled with ignored loads, unused ops and a stray allocation.
   task automatic random_batch();
      int       nrec;
      item_type it;
      nrec = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) begin
         it = '{op: OP_ALLOC, slot_used: 1'($urandom()), entry_addr: $urandom(),
                entry_size: $urandom(), alloc_len: pick_alloc_len()};
         send_plain(it);
      end
      for (int i = 0; i < nrec; i++) begin
         if ($urandom_range(0, 6) == 0)
            send_plain(pick_noise());
         it = '{op: OP_LOAD, slot_used: 1'b1, entry_addr: pick_record_addr(),
                entry_size: pick_record_size(), alloc_len: $urandom()};
         send_plain(it);
      end
      it = '{op: OP_REBUILD, slot_used: 1'($urandom()), entry_addr: $urandom(),
             entry_size: $urandom(), alloc_len: $urandom()};
      send_plain(it);
      repeat ($urandom_range(2, 10)) begin
         it = '{op: OP_ALLOC, slot_used: 1'($urandom()), entry_addr: $urandom(),
                entry_size: $urandom(), alloc_len: pick_alloc_len()};
         send_plain(it);
      end
   endtask

   // Configuration settings, extremes included. Each setting writes both registers.
   task automatic random_config();
      logic [31:0] rs, fe;
      case ($urandom_range(0, 6))
         0: begin rs = 32'd0;          fe = 32'hFFFF_FFFF; end
         1: begin rs = 32'hFFFF_F000;  fe = 32'hFFFF_FFFF; end
         2: begin rs = 32'h0010_0000;  fe = 32'h0008_0000; end  // end below start
         3: begin rs = $urandom();     fe = $urandom();     end
         4: begin rs = 32'h0000_1000;  fe = 32'h0100_0000; end
         default: begin
            rs = $urandom_range(0, 4096) * SECTOR;
            fe = rs + $urandom_range(0, 2048) * SECTOR + $urandom_range(0, 4095);
         end
      endcase
      write_csr(CSR_REGION_START, rs);
      write_csr(CSR_FLASH_END, fe);
   endtask

   // ---------------------------------------------------------------------
   // Directed table. Typed rows carry their result; the rest use the shadow.
   // Starts from reset values: region 0x1000, end 0x0100_0000.
   // ---------------------------------------------------------------------
   row_type dir_rows [NUM_DIRECTED];

   initial begin
      dir_rows = '{
         // allocate with no extents at all
         '{'{OP_ALLOC,   1'b0, 32'h0, 32'h0, 32'h0},          1'b1, '{32'h0, 1'b0, ST_NOFIT, 6'd0}},
         // rebuild with an empty store: only the tail extent
         '{'{OP_REBUILD, 1'b0, 32'h0, 32'h0, 32'h0},          1'b1, '{32'h0, 1'b0, ST_DONE, 6'd1}},
         // zero length request splits the tail
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'h0},          1'b1, '{32'h1000, 1'b1, ST_DONE, 6'd1}},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF},  1'b1, '{32'h0, 1'b0, ST_NOFIT, 6'd1}},
         // loads the filter drops, and the unused op
         '{'{OP_LOAD,    1'b0, 32'h2000, 32'h10, 32'h0},      1'b1, '{32'h0, 1'b0, ST_DONE, 6'd1}},
         '{'{OP_LOAD,    1'b1, ADDR_NONE, 32'h10, 32'h0},     1'b1, '{32'h0, 1'b0, ST_DONE, 6'd1}},
         '{'{OP_LOAD,    1'b1, 32'h2000, 32'h0, 32'h0},       1'b1, '{32'h0, 1'b0, ST_DONE, 6'd1}},
         '{'{OP_NONE,    1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                                                              1'b1, '{32'h0, 1'b0, ST_DONE, 6'd1}},
         // records: equal addresses, overlap, end past 4 GiB
         '{'{OP_LOAD,    1'b1, 32'h0001_0000, 32'h1, 32'h0},  1'b0, '0},
         '{'{OP_LOAD,    1'b1, 32'h0000_8000, 32'h2000, 32'h0}, 1'b0, '0},
         '{'{OP_LOAD,    1'b1, 32'h0000_8000, 32'h1000, 32'h0}, 1'b0, '0},
         '{'{OP_LOAD,    1'b1, 32'h0000_9000, 32'h5, 32'h0},  1'b0, '0},
         '{'{OP_LOAD,    1'b1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0},
         '{'{OP_REBUILD, 1'b1, 32'h0, 32'h0, 32'h0},          1'b0, '0},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'h1000},       1'b0, '0},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'h0FFF},       1'b0, '0},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'h1},          1'b0, '0},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'h3000},       1'b0, '0},
         // record below the region start is skipped as overlap
         '{'{OP_LOAD,    1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0},  1'b0, '0},
         '{'{OP_REBUILD, 1'b1, 32'h0, 32'h0, 32'h0},          1'b0, '0},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF},  1'b1, '{32'h0, 1'b0, ST_NOFIT, 6'd1}},
         '{'{OP_ALLOC,   1'b1, 32'h0, 32'h0, 32'h00FF_E000},  1'b0, '0}
      };
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int batches;
      errors          = 0;
      items_taken     = 0;
      csr_taken       = 0;
      items_sent      = 0;
      stall_count     = 0;
      use_typed       = 1'b0;
      typed_res       = '0;
      idling_on       = 1'b1;
      sh_region_start = 32'h0000_1000;
      sh_flash_end    = 32'h0100_0000;
      rec_n           = 0;
      ext_n           = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = OP_LOAD;
      req_slot_used   = 1'b0;
      req_entry_addr  = '0;
      req_entry_size  = '0;
      req_alloc_len   = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_REGION_START;
      csr_wdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
      use_typed = 1'b0;

      // Random part; the register setting changes every few sequences
      // (drain inside write_csr is the full pause of the sender).
      batches = 0;
      while (items_sent < NUM_ITEMS) begin
         if (batches % 3 == 0)
            random_config();
         random_batch();
         batches++;
      end

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: flash_extent_allocator.f
rtl/fea_pkg.sv
rtl/fea_ram.sv
rtl/flash_extent_allocator.sv
rtl/fea_check.sv
tb/tb_flash_extent_allocator.sv
